FILE: hw/rtl/glm_pkg.sv
// Shared types, constants and the low-point compare for the grid minimum finder.
`timescale 1ns / 1ps

package glm_pkg;

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] DIM_RESET = 8'd128;

  localparam int ROW_OUT_W    = 7;
  localparam int COL_OUT_W    = 7;
  localparam int HEIGHT_OUT_W = 4;
  localparam int RISK_W       = 24;

  localparam logic [RISK_W-1:0] RISK_MAX = 24'hFFFFFF;

  // Widest sample the compare function takes.
  localparam int SAMPLE_MAX_W = 16;

  localparam int QUEUE_DEPTH = 8;
  localparam int PUSH_MAX    = 3;
  localparam int PUSH_W      = 2;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SAMPLE_MAX_W-1:0] sample_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0]    row;
    logic [COL_OUT_W-1:0]    col;
    logic [HEIGHT_OUT_W-1:0] height;
    logic [RISK_W-1:0]       total;
    logic                    done;
  } result_t;

  typedef struct packed {
    logic              shift;
    logic [CNT_W-1:0]  base;
    logic [PUSH_W-1:0] npush;
  } queue_ctrl_t;

  // Strictly lower than every neighbor that exists.
  function automatic logic is_low(sample_t v,
                                  logic hu, sample_t u,
                                  logic hd, sample_t d,
                                  logic hl, sample_t l,
                                  logic hr, sample_t r);
    return (!hu || (u > v)) && (!hd || (d > v)) && (!hl || (l > v)) && (!hr || (r > v));
  endfunction

endpackage

FILE: hw/rtl/glm_line_store.sv
// Column-indexed line store: one write port, two registered read ports with write bypass.
`timescale 1ns / 1ps

module glm_line_store #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Return the word being written when a read hits the same column.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr_a)) begin
      rd_data_a <= wr_data;
    end else begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (wr_en && (wr_addr == rd_addr_b)) begin
      rd_data_b <= wr_data;
    end else begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: hw/rtl/glm_queue_cell.sv
// One slot of the collapsing result queue; takes a new result or its upper neighbor.
`timescale 1ns / 1ps

module glm_queue_cell
  import glm_pkg::*;
(
  input  logic             clk,
  input  logic [CNT_W-1:0] slot_index,
  input  queue_ctrl_t      ctrl,
  input  result_t          push_ent [PUSH_MAX],
  input  result_t          upper,
  output result_t          ent
);

  logic [CNT_W-1:0] offset;
  logic             take_push;

  assign offset    = slot_index - ctrl.base;
  assign take_push = (slot_index >= ctrl.base) && (offset < CNT_W'(ctrl.npush));

  always_ff @(posedge clk) begin
    if (take_push) begin
      ent <= push_ent[offset[PUSH_W-1:0]];
    end else if (ctrl.shift) begin
      ent <= upper;
    end
  end

endmodule

FILE: hw/rtl/grid_local_minimum_finder.sv
// Top level of the grid local minimum finder. Height samples arrive in row-major order, one per
// transfer, and the block takes one sample per clock. A pixel is reported when it is strictly
// lower than its four neighbors (neighbors outside the frame count as higher); each pixel is
// judged when the pixel below it arrives, last-row pixels when the pixel to their right arrives,
// and the frame's last pixel judges itself and adds a done result carrying the saturating sum of
// height plus one over the frame's low points. The two previous rows live in one column-indexed
// line store whose two read ports are fetched one sample ahead, so a sample's neighbors are
// ready when it arrives. Results leave one per clock while the output side accepts them,
// through an eight-slot collapsing queue built from a chain of slots, after the accumulate
// stage register. The intake takes a sample whenever the queue, counting results still in
// flight, has room for three more, the largest burst one sample can bring (the low above, the
// low to the left and the done result at a frame's last pixel). The rate is one sample per
// clock as long as the output side keeps up with the results; a held-off output side stalls the
// intake once more than five results are queued or in flight. The line store is not cleared
// after reset; frame size registers may be written between frames.
`timescale 1ns / 1ps

module grid_local_minimum_finder
  import glm_pkg::*;
#(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int SAMPLE_BITS = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  // sample channel
  input  logic                    pixel_valid,
  output logic                    pixel_ready,
  input  logic [SAMPLE_BITS-1:0]  pixel_height,
  // result channel
  output logic                    point_valid,
  input  logic                    point_ready,
  output logic [ROW_OUT_W-1:0]    point_row,
  output logic [COL_OUT_W-1:0]    point_col,
  output logic [HEIGHT_OUT_W-1:0] point_height,
  output logic [RISK_W-1:0]       risk_total,
  output logic                    frame_done
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
  localparam int DM_W   = (WD_W > HD_W) ? WD_W : HD_W;
  localparam int DIM_W  = (DM_W > CFG_W) ? DM_W : CFG_W;
  localparam int ADD_W  = SAMPLE_BITS + 1;
  localparam int PRE_W  = SAMPLE_BITS + 3;
  localparam int MEM_W  = 2 * SAMPLE_BITS;
  localparam int ENT_N  = PUSH_MAX + 1;

  // ---------------------------------------------------------------------------------------------
  // Configuration registers and clamped frame size
  // ---------------------------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [DIM_W-1:0] dim_w;
  logic [DIM_W-1:0] dim_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero reads as one; anything past the maximum reads as the maximum.
  always_comb begin
    dim_w = DIM_W'(frame_width);
    if (frame_width == '0) begin
      dim_w = DIM_W'(1);
    end else if (dim_w > DIM_W'(MAX_WIDTH)) begin
      dim_w = DIM_W'(MAX_WIDTH);
    end
    dim_h = DIM_W'(frame_height);
    if (frame_height == '0) begin
      dim_h = DIM_W'(1);
    end else if (dim_h > DIM_W'(MAX_HEIGHT)) begin
      dim_h = DIM_W'(MAX_HEIGHT);
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Position, left-hand history and line store
  // ---------------------------------------------------------------------------------------------
  logic [COL_W-1:0]       col_count;
  logic [ROW_W-1:0]       row_count;
  logic [COL_W-1:0]       col_next;
  logic [COL_W-1:0]       col_ahead;
  logic [SAMPLE_BITS-1:0] lh0;       // row above, one column left
  logic [SAMPLE_BITS-1:0] lh1;       // this row, one column left
  logic [SAMPLE_BITS-1:0] left_far;  // this row, two columns left
  logic [MEM_W-1:0]       rd_a;
  logic [MEM_W-1:0]       rd_b;
  logic [SAMPLE_BITS-1:0] prev_c;
  logic [SAMPLE_BITS-1:0] older_c;
  logic [SAMPLE_BITS-1:0] prev_c1;
  logic                   pixel_acc;
  logic                   last_col;
  logic                   last_row;
  logic                   frame_end;

  assign pixel_acc = pixel_valid && pixel_ready;
  assign last_col  = (DIM_W'(col_count) + DIM_W'(1)) >= dim_w;
  assign last_row  = (DIM_W'(row_count) + DIM_W'(1)) >= dim_h;
  assign frame_end = last_col && last_row;

  // Store word per column: older row in the upper half, previous row in the lower half.
  assign older_c = rd_a[MEM_W-1:SAMPLE_BITS];
  assign prev_c  = rd_a[SAMPLE_BITS-1:0];
  assign prev_c1 = rd_b[SAMPLE_BITS-1:0];

  // Fetch the column of the next sample and its right neighbor before that sample arrives.
  always_comb begin
    col_next = col_count;
    if (pixel_acc) begin
      col_next = last_col ? '0 : col_count + COL_W'(1);
    end
    col_ahead = (col_next == COL_W'(MAX_WIDTH - 1)) ? col_next : col_next + COL_W'(1);
  end

  glm_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W),
    .DATA_W (MEM_W)
  ) u_line_store (
    .clk       (clk),
    .wr_en     (pixel_acc),
    .wr_addr   (col_count),
    .wr_data   ({prev_c, pixel_height}),
    .rd_addr_a (col_next),
    .rd_addr_b (col_ahead),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      lh0       <= '0;
      lh1       <= '0;
    end else if (pixel_acc) begin
      col_count <= col_next;
      if (frame_end) begin
        row_count <= '0;
        lh0       <= '0;
        lh1       <= '0;
      end else begin
        if (last_col) begin
          row_count <= row_count + ROW_W'(1);
        end
        lh0      <= prev_c;
        lh1      <= pixel_height;
        left_far <= lh1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Judgement: pixel above, left pixel on the last row, the last pixel itself
  // ---------------------------------------------------------------------------------------------
  logic                   has_up;
  logic                   has_up2;
  logic                   has_left;
  logic                   has_left2;
  logic                   f_up;
  logic                   f_left;
  logic                   f_self;
  result_t                ent     [ENT_N];
  logic [ENT_N-1:0]       ent_ok;
  logic [ADD_W-1:0]       ent_add [ENT_N];
  result_t                a_slot  [PUSH_MAX];
  logic [ADD_W-1:0]       a_add   [PUSH_MAX];
  logic [PRE_W-1:0]       a_pre   [PUSH_MAX];
  logic [PUSH_W-1:0]      a_npush;

  assign has_up    = row_count != '0;
  assign has_up2   = row_count > ROW_W'(1);
  assign has_left  = col_count != '0;
  assign has_left2 = col_count > COL_W'(1);

  assign f_up = has_up &&
                is_low(sample_t'(prev_c), has_up2, sample_t'(older_c),
                       1'b1, sample_t'(pixel_height), has_left, sample_t'(lh0),
                       !last_col, sample_t'(prev_c1));

  assign f_left = last_row && has_left &&
                  is_low(sample_t'(lh1), has_up, sample_t'(lh0),
                         1'b0, '0, has_left2, sample_t'(left_far),
                         1'b1, sample_t'(pixel_height));

  assign f_self = frame_end &&
                  is_low(sample_t'(pixel_height), has_up, sample_t'(prev_c),
                         1'b0, '0, has_left, sample_t'(lh1), 1'b0, '0);

  always_comb begin
    ent_ok     = {frame_end, f_self, f_left, f_up};

    ent[0]     = '{row: ROW_OUT_W'(row_count - ROW_W'(1)), col: COL_OUT_W'(col_count),
                   height: HEIGHT_OUT_W'(prev_c), total: '0, done: 1'b0};
    ent_add[0] = ADD_W'(prev_c) + ADD_W'(1);

    ent[1]     = '{row: ROW_OUT_W'(row_count), col: COL_OUT_W'(col_count - COL_W'(1)),
                   height: HEIGHT_OUT_W'(lh1), total: '0, done: 1'b0};
    ent_add[1] = ADD_W'(lh1) + ADD_W'(1);

    ent[2]     = '{row: ROW_OUT_W'(row_count), col: COL_OUT_W'(col_count),
                   height: HEIGHT_OUT_W'(pixel_height), total: '0, done: 1'b0};
    ent_add[2] = ADD_W'(pixel_height) + ADD_W'(1);

    ent[3]     = '{row: '0, col: '0, height: '0, total: '0, done: 1'b1};
    ent_add[3] = '0;
  end

  // Pack the valid results to the front; at most three are valid at once, since neighbors
  // can never both be low.
  always_comb begin
    logic [PUSH_W:0] pos;
    pos = '0;
    for (int s = 0; s < PUSH_MAX; s++) begin
      a_slot[s] = '0;
      a_add[s]  = '0;
    end
    for (int k = 0; k < ENT_N; k++) begin
      if (ent_ok[k]) begin
        if (pos < (PUSH_W+1)'(PUSH_MAX)) begin
          a_slot[pos[PUSH_W-1:0]] = ent[k];
          a_add[pos[PUSH_W-1:0]]  = ent_add[k];
        end
        pos = pos + (PUSH_W+1)'(1);
      end
    end
    a_npush = pos[PUSH_W-1:0];
  end

  // Running sum of addends; unused slots add zero so the last slot holds the item's total.
  always_comb begin
    a_pre[0] = PRE_W'(a_add[0]);
    for (int s = 1; s < PUSH_MAX; s++) begin
      a_pre[s] = a_pre[s-1] + PRE_W'(a_add[s]);
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Accumulate stage: saturating totals, then hand the results to the queue
  // ---------------------------------------------------------------------------------------------
  result_t           b_slot [PUSH_MAX];
  logic [PRE_W-1:0]  b_pre  [PUSH_MAX];
  logic [PUSH_W-1:0] npush_b;
  logic              b_done;
  logic [RISK_W-1:0] risk_acc;
  logic [RISK_W:0]   b_sum  [PUSH_MAX];
  logic [RISK_W-1:0] b_tot  [PUSH_MAX];
  result_t           push_ent [PUSH_MAX];

  always_ff @(posedge clk) begin
    if (rst) begin
      npush_b <= '0;
      b_done  <= 1'b0;
    end else if (pixel_acc) begin
      npush_b <= a_npush;
      b_done  <= frame_end;
    end else begin
      npush_b <= '0;
      b_done  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    b_slot <= a_slot;
    b_pre  <= a_pre;
  end

  // Saturating once on the whole partial sum equals saturating after every add.
  always_comb begin
    for (int s = 0; s < PUSH_MAX; s++) begin
      b_sum[s]          = (RISK_W+1)'(risk_acc) + (RISK_W+1)'(b_pre[s]);
      b_tot[s]          = b_sum[s][RISK_W] ? RISK_MAX : b_sum[s][RISK_W-1:0];
      push_ent[s]       = b_slot[s];
      push_ent[s].total = b_tot[s];
    end
  end

  // Clear the total after the frame's done result.
  always_ff @(posedge clk) begin
    if (rst) begin
      risk_acc <= '0;
    end else if (npush_b != '0) begin
      risk_acc <= b_done ? '0 : b_tot[PUSH_MAX-1];
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Result queue: chain of slots, head at slot zero, shift down on every output transfer
  // ---------------------------------------------------------------------------------------------
  logic [CNT_W-1:0] q_count;
  logic             pop;
  queue_ctrl_t      q_ctrl;
  result_t          q_ent [QUEUE_DEPTH];

  assign pop          = point_valid && point_ready;
  assign q_ctrl.shift = pop;
  assign q_ctrl.base  = q_count - CNT_W'(pop);
  assign q_ctrl.npush = npush_b;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    result_t upper_ent;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign upper_ent = '0;
    end else begin : g_body
      assign upper_ent = q_ent[i+1];
    end
    glm_queue_cell u_slot (
      .clk        (clk),
      .slot_index (CNT_W'(i)),
      .ctrl       (q_ctrl),
      .push_ent   (push_ent),
      .upper      (upper_ent),
      .ent        (q_ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      q_count <= q_count - CNT_W'(pop) + CNT_W'(npush_b);
    end
  end

  // Hold intake until the queue can absorb a full burst on top of what is in flight.
  assign pixel_ready = ((CNT_W+1)'(q_count) + (CNT_W+1)'(npush_b) + (CNT_W+1)'(PUSH_MAX))
                       <= (CNT_W+1)'(QUEUE_DEPTH);

  assign point_valid  = q_count != '0;
  assign point_row    = q_ent[0].row;
  assign point_col    = q_ent[0].col;
  assign point_height = q_ent[0].height;
  assign risk_total   = q_ent[0].total;
  assign frame_done   = q_ent[0].done;

  // ---------------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------------
  a_queue_room : assert property (@(posedge clk) disable iff (rst)
    ((CNT_W+1)'(q_count) + (CNT_W+1)'(npush_b)) <= (CNT_W+1)'(QUEUE_DEPTH))
    else $error("result queue would overflow");

  a_frame_wrap : assert property (@(posedge clk) disable iff (rst)
    pixel_acc && frame_end |=> (col_count == '0) && (row_count == '0))
    else $error("position not cleared after last pixel of frame");

  a_done_pushed : assert property (@(posedge clk) disable iff (rst)
    b_done |-> (npush_b != '0))
    else $error("frame end without a done result");

  a_total_clear : assert property (@(posedge clk) disable iff (rst)
    b_done |=> (risk_acc == '0))
    else $error("risk total not cleared after done result");

endmodule
